// File: sv/etf_pkg.sv
// Shared types, register codes and arithmetic constants of the escape-time pixel block.
package etf_pkg;

    // Image geometry and fixed-point format (signed Q6.26 held in 32 bits).
    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 768;
    localparam int FRAC_BITS    = 26;
    localparam int Z_W          = 32;
    localparam int PROD_Z_W     = 2 * Z_W;
    localparam int JC_W         = 28;
    localparam int PIX_W        = 10;
    localparam int CNT_W        = 8;
    localparam int COLOR_W      = 8;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_MODE     = 2'd0,
        REG_MAX_ITER = 2'd1,
        REG_C_RE     = 2'd2,
        REG_C_IM     = 2'd3
    } t_reg_idx;

    localparam logic MODE_MANDEL = 1'b0;
    localparam logic MODE_JULIA  = 1'b1;

    localparam logic                    MODE_RST     = MODE_MANDEL;
    localparam logic [CNT_W-1:0]        MAX_ITER_RST = 8'd100;
    localparam logic signed [JC_W-1:0]  C_RE_RST     = -28'sd47094316;
    localparam logic signed [JC_W-1:0]  C_IM_RST     = -28'sd25783226;

    // Pixel to plane mapping: value = sign(n) * floor(|n| * mul * 2^26 / div),
    // with the division done as a multiply by a rounded-up reciprocal.
    localparam int MB_SCALE  = 180;
    localparam int MB_OFF_X  = (IMAGE_WIDTH / 4) * 3;
    localparam int MB_OFF_Y  = IMAGE_HEIGHT / 2;
    localparam int JU_OFF_X  = IMAGE_WIDTH / 2;
    localparam int JU_OFF_Y  = IMAGE_HEIGHT / 2;
    localparam int MB_MUL    = 1;
    localparam int JU_MUL_X  = 3;
    localparam int JU_MUL_Y  = 2;
    localparam int MUL_W     = 2;

    localparam int COORD_W     = 13;  // pixel minus offset, signed
    localparam int ABS_W       = COORD_W - 1;
    localparam int ABS_MUL_W   = ABS_W + MUL_W;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_EXP   = FRAC_BITS + RECIP_SHIFT;
    localparam int K_W         = 49;
    localparam int K_LO_W      = 24;
    localparam int K_HI_W      = K_W - K_LO_W;
    localparam int MAP_PROD_W  = ABS_MUL_W + K_W;
    localparam int MAP_Q_W     = MAP_PROD_W - RECIP_SHIFT;

    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_EXP;
    localparam logic [K_W-1:0] K_MB =
        K_W'((RECIP_ONE + 64'(MB_SCALE) - 64'd1) / 64'(MB_SCALE));
    localparam logic [K_W-1:0] K_JX =
        K_W'((RECIP_ONE + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH));
    localparam logic [K_W-1:0] K_JY =
        K_W'((RECIP_ONE + 64'(IMAGE_HEIGHT) - 64'd1) / 64'(IMAGE_HEIGHT));

    // Escape bound on |z|^2 in Q.52.
    localparam logic [PROD_Z_W-1:0] ESC_SQ = 64'd16 << (2 * FRAC_BITS);

    // Colors. floor(m*i/10) = (i * m * 3277) >> 15 over the whole count range.
    localparam int DIV10_SHIFT   = 15;
    localparam int DIV10_K       = 3277;
    localparam int COLOR_K_W     = 15;
    localparam int RED_BASE      = 10;
    localparam int GREEN_BASE    = 20;
    localparam int BLUE_BASE     = 30;
    localparam int RED_K         = 6 * DIV10_K;
    localparam int GREEN_K       = 9 * DIV10_K;
    localparam int BLUE_K        = 3 * DIV10_K;
    localparam int JU_COLOR_MUL  = 9;
    localparam int JU_COLOR_W    = 12;
    localparam int COLOR_MOD     = 255;

    typedef struct packed {
        logic                   mode;
        logic [CNT_W-1:0]       max_iter;
        logic signed [JC_W-1:0] c_re;
        logic signed [JC_W-1:0] c_im;
    } t_cfg;

    typedef struct packed {
        logic load_pix;
        logic map_abs;
        logic map_mul;
        logic map_init;
        logic mul;
        logic z_update;
        logic cnt_inc;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_lt_max;
        logic cnt1_lt_max;
        logic mag_lt;
        logic mag_gt;
    } t_dp_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_ABS,
        ST_MAP_MUL,
        ST_MAP_INIT,
        ST_MUL,
        ST_STEP,
        ST_DONE
    } t_state;

endpackage

// File: sv/etf_regs.sv
// Configuration register file behind the APB-style port.
module etf_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [etf_pkg::ADDR_W-1:0]  paddr,
    input  logic [etf_pkg::DATA_W-1:0]  pwdata,
    output logic [etf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output etf_pkg::t_cfg               o_cfg
);

    etf_pkg::t_cfg    r_cfg;
    etf_pkg::t_reg_idx idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = etf_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= etf_pkg::MODE_RST;
            r_cfg.max_iter <= etf_pkg::MAX_ITER_RST;
            r_cfg.c_re     <= etf_pkg::C_RE_RST;
            r_cfg.c_im     <= etf_pkg::C_IM_RST;
        end else if (wr_en) begin
            unique case (idx)
                etf_pkg::REG_MODE:     r_cfg.mode     <= pwdata[0];
                etf_pkg::REG_MAX_ITER: r_cfg.max_iter <= pwdata[etf_pkg::CNT_W-1:0];
                etf_pkg::REG_C_RE:     r_cfg.c_re     <= signed'(pwdata[etf_pkg::JC_W-1:0]);
                etf_pkg::REG_C_IM:     r_cfg.c_im     <= signed'(pwdata[etf_pkg::JC_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            etf_pkg::REG_MODE:
                prdata = etf_pkg::DATA_W'(r_cfg.mode);
            etf_pkg::REG_MAX_ITER:
                prdata = etf_pkg::DATA_W'(r_cfg.max_iter);
            etf_pkg::REG_C_RE:
                prdata = etf_pkg::DATA_W'(r_cfg.c_re);
            etf_pkg::REG_C_IM:
                prdata = etf_pkg::DATA_W'(r_cfg.c_im);
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: sv/etf_ctrl.sv
// Sequencer: pixel mapping steps, then multiply/step pairs until escape or limit.
module etf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_mode,
    input  etf_pkg::t_dp_stat i_stat,
    output etf_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    etf_pkg::t_state r_state, n_state;
    logic            r_upd, n_upd;  // Julia: z already updated, check pending

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etf_pkg::ST_IDLE;
            r_upd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_upd   <= n_upd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_upd   = r_upd;
        o_cmd   = '0;
        unique case (r_state)
            etf_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load_pix = 1'b1;
                    n_state        = etf_pkg::ST_MAP_ABS;
                end
            end
            etf_pkg::ST_MAP_ABS: begin
                o_cmd.map_abs = 1'b1;
                n_state       = etf_pkg::ST_MAP_MUL;
            end
            etf_pkg::ST_MAP_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state       = etf_pkg::ST_MAP_INIT;
            end
            etf_pkg::ST_MAP_INIT: begin
                o_cmd.map_init = 1'b1;
                n_upd          = 1'b0;
                n_state        = etf_pkg::ST_MUL;
            end
            etf_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = etf_pkg::ST_STEP;
            end
            etf_pkg::ST_STEP: begin
                n_state = etf_pkg::ST_DONE;
                if (i_mode == etf_pkg::MODE_MANDEL) begin
                    if (i_stat.cnt_lt_max && i_stat.mag_lt) begin
                        o_cmd.z_update = 1'b1;
                        o_cmd.cnt_inc  = 1'b1;
                        n_state        = etf_pkg::ST_MUL;
                    end
                end else if (!r_upd) begin
                    // first update happens before any escape check
                    if (i_stat.cnt_lt_max) begin
                        o_cmd.z_update = 1'b1;
                        n_upd          = 1'b1;
                        n_state        = etf_pkg::ST_MUL;
                    end
                end else if (!i_stat.mag_gt) begin
                    o_cmd.cnt_inc = 1'b1;
                    if (i_stat.cnt1_lt_max) begin
                        o_cmd.z_update = 1'b1;
                        n_state        = etf_pkg::ST_MUL;
                    end
                end
            end
            etf_pkg::ST_DONE: begin
                o_cmd.out_load = 1'b1;
                n_state        = etf_pkg::ST_IDLE;
            end
            default: begin
                n_state = etf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != etf_pkg::ST_IDLE);

endmodule

// File: sv/etf_dp.sv
// Datapath: coordinate mapping, z = z*z + c iteration, escape test and coloring.
module etf_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  etf_pkg::t_cfg                i_cfg,
    input  etf_pkg::t_dp_cmd             i_cmd,
    input  logic [etf_pkg::PIX_W-1:0]    i_pixel_x,
    input  logic [etf_pkg::PIX_W-1:0]    i_pixel_y,
    output etf_pkg::t_dp_stat            o_stat,
    output logic [etf_pkg::COLOR_W-1:0]  o_red,
    output logic [etf_pkg::COLOR_W-1:0]  o_green,
    output logic [etf_pkg::COLOR_W-1:0]  o_blue,
    output logic [etf_pkg::CNT_W-1:0]    o_iteration_count,
    output logic                         o_valid
);

    localparam int ZR_SH_W = etf_pkg::PROD_Z_W - etf_pkg::FRAC_BITS;
    localparam int ZI_SH_W = etf_pkg::PROD_Z_W - etf_pkg::FRAC_BITS + 1;
    localparam int SUM_W   = ZI_SH_W + 1;
    localparam int CPROD_W = etf_pkg::CNT_W + etf_pkg::COLOR_K_W;
    localparam int HI_W    = etf_pkg::ABS_MUL_W + etf_pkg::K_HI_W;
    localparam int LO_W    = etf_pkg::ABS_MUL_W + etf_pkg::K_LO_W;

    // Saturate a mapped magnitude with its sign into Q6.26.
    function automatic logic signed [etf_pkg::Z_W-1:0] f_sat_map(
        input logic [etf_pkg::MAP_Q_W-1:0] q,
        input logic                        neg
    );
        logic signed [etf_pkg::Z_W-1:0] res;
        if (!neg) begin
            if (q > etf_pkg::MAP_Q_W'(32'h7FFF_FFFF)) res = 32'sh7FFF_FFFF;
            else                                      res = signed'(q[etf_pkg::Z_W-1:0]);
        end else begin
            if (q >= etf_pkg::MAP_Q_W'(32'h8000_0000)) res = 32'sh8000_0000;
            else                                       res = -signed'(q[etf_pkg::Z_W-1:0]);
        end
        return res;
    endfunction

    function automatic logic signed [etf_pkg::Z_W-1:0] f_sat_z(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [etf_pkg::Z_W-1:0] res;
        if (v > SUM_W'(64'sh7FFF_FFFF))        res = 32'sh7FFF_FFFF;
        else if (v < -SUM_W'(64'sh8000_0000))  res = 32'sh8000_0000;
        else                                   res = v[etf_pkg::Z_W-1:0];
        return res;
    endfunction

    logic [etf_pkg::PIX_W-1:0]            r_x, r_y;
    logic [etf_pkg::ABS_MUL_W-1:0]        r_a_re, r_a_im;
    logic                                 r_neg_re, r_neg_im;
    logic [HI_W-1:0]                      r_p_re_hi, r_p_im_hi;
    logic [LO_W-1:0]                      r_p_re_lo, r_p_im_lo;
    logic signed [etf_pkg::Z_W-1:0]       r_zr, r_zi, r_cr, r_ci;
    logic signed [etf_pkg::PROD_Z_W-1:0]  r_aa, r_bb, r_ab;
    logic [etf_pkg::CNT_W-1:0]            r_cnt;
    logic [etf_pkg::COLOR_W-1:0]          r_red, r_green, r_blue;
    logic [etf_pkg::CNT_W-1:0]            r_iter_out;
    logic                                 r_valid;

    logic signed [etf_pkg::COORD_W-1:0]   off_x, off_y, n_re, n_im;
    logic [etf_pkg::MUL_W-1:0]            mul_x, mul_y;
    logic [etf_pkg::ABS_W-1:0]            abs_re, abs_im;
    logic [etf_pkg::K_W-1:0]              k_re, k_im;
    logic [etf_pkg::MAP_PROD_W-1:0]       sum_re, sum_im;
    logic signed [etf_pkg::Z_W-1:0]       map_re, map_im;
    logic signed [etf_pkg::PROD_Z_W-1:0]  diff;
    logic signed [SUM_W-1:0]              nr, ni;
    logic [etf_pkg::PROD_Z_W-1:0]         mag;
    logic [CPROD_W-1:0]                   p_red, p_green, p_blue;
    logic [etf_pkg::JC_W-1:0]             unused_c;
    logic [etf_pkg::JU_COLOR_W-1:0]       v9;
    logic [etf_pkg::COLOR_W:0]            s9;
    logic [etf_pkg::COLOR_W-1:0]          ju_col;

    // Pixel offsets, multipliers and reciprocals per mode.
    always_comb begin
        if (i_cfg.mode == etf_pkg::MODE_JULIA) begin
            off_x = etf_pkg::COORD_W'(etf_pkg::JU_OFF_X);
            off_y = etf_pkg::COORD_W'(etf_pkg::JU_OFF_Y);
            mul_x = etf_pkg::MUL_W'(etf_pkg::JU_MUL_X);
            mul_y = etf_pkg::MUL_W'(etf_pkg::JU_MUL_Y);
            k_re  = etf_pkg::K_JX;
            k_im  = etf_pkg::K_JY;
        end else begin
            off_x = etf_pkg::COORD_W'(etf_pkg::MB_OFF_X);
            off_y = etf_pkg::COORD_W'(etf_pkg::MB_OFF_Y);
            mul_x = etf_pkg::MUL_W'(etf_pkg::MB_MUL);
            mul_y = etf_pkg::MUL_W'(etf_pkg::MB_MUL);
            k_re  = etf_pkg::K_MB;
            k_im  = etf_pkg::K_MB;
        end
    end

    assign n_re   = signed'(etf_pkg::COORD_W'(r_x)) - off_x;
    assign n_im   = signed'(etf_pkg::COORD_W'(r_y)) - off_y;
    assign abs_re = n_re[etf_pkg::COORD_W-1] ? etf_pkg::ABS_W'(-n_re) : etf_pkg::ABS_W'(n_re);
    assign abs_im = n_im[etf_pkg::COORD_W-1] ? etf_pkg::ABS_W'(-n_im) : etf_pkg::ABS_W'(n_im);

    assign sum_re = {r_p_re_hi, etf_pkg::K_LO_W'(0)} + etf_pkg::MAP_PROD_W'(r_p_re_lo);
    assign sum_im = {r_p_im_hi, etf_pkg::K_LO_W'(0)} + etf_pkg::MAP_PROD_W'(r_p_im_lo);
    assign map_re = f_sat_map(sum_re[etf_pkg::MAP_PROD_W-1:etf_pkg::RECIP_SHIFT], r_neg_re);
    assign map_im = f_sat_map(sum_im[etf_pkg::MAP_PROD_W-1:etf_pkg::RECIP_SHIFT], r_neg_im);

    // Update: re = floor((a^2 - b^2) / 2^26) + cr, im = floor(a*b / 2^25) + ci.
    assign diff = r_aa - r_bb;
    assign nr   = SUM_W'(signed'(diff[etf_pkg::PROD_Z_W-1:etf_pkg::FRAC_BITS])) + SUM_W'(r_cr);
    assign ni   = SUM_W'(signed'(r_ab[etf_pkg::PROD_Z_W-1:etf_pkg::FRAC_BITS-1])) + SUM_W'(r_ci);
    assign mag  = unsigned'(r_aa) + unsigned'(r_bb);

    assign o_stat.cnt_lt_max  = (r_cnt < i_cfg.max_iter);
    assign o_stat.cnt1_lt_max =
        ((etf_pkg::CNT_W + 1)'(r_cnt) + (etf_pkg::CNT_W + 1)'(1)) < (etf_pkg::CNT_W + 1)'(i_cfg.max_iter);
    assign o_stat.mag_lt = (mag < etf_pkg::ESC_SQ);
    assign o_stat.mag_gt = (mag > etf_pkg::ESC_SQ);

    // Colors from the final count.
    assign p_red   = CPROD_W'(r_cnt) * CPROD_W'(etf_pkg::RED_K);
    assign p_green = CPROD_W'(r_cnt) * CPROD_W'(etf_pkg::GREEN_K);
    assign p_blue  = CPROD_W'(r_cnt) * CPROD_W'(etf_pkg::BLUE_K);
    assign v9      = etf_pkg::JU_COLOR_W'(r_cnt) * etf_pkg::JU_COLOR_W'(etf_pkg::JU_COLOR_MUL);
    // mod 255: 256 folds to 1, so add high and low bytes and correct once
    assign s9      = (etf_pkg::COLOR_W + 1)'(v9[etf_pkg::JU_COLOR_W-1:etf_pkg::COLOR_W])
                   + (etf_pkg::COLOR_W + 1)'(v9[etf_pkg::COLOR_W-1:0]);
    assign ju_col  = (s9 >= (etf_pkg::COLOR_W + 1)'(etf_pkg::COLOR_MOD))
                   ? etf_pkg::COLOR_W'(s9 - (etf_pkg::COLOR_W + 1)'(etf_pkg::COLOR_MOD))
                   : s9[etf_pkg::COLOR_W-1:0];
    assign unused_c = '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_x <= i_pixel_x;
            r_y <= i_pixel_y;
        end
        if (i_cmd.map_abs) begin
            r_a_re   <= etf_pkg::ABS_MUL_W'(abs_re) * etf_pkg::ABS_MUL_W'(mul_x);
            r_a_im   <= etf_pkg::ABS_MUL_W'(abs_im) * etf_pkg::ABS_MUL_W'(mul_y);
            r_neg_re <= n_re[etf_pkg::COORD_W-1];
            r_neg_im <= n_im[etf_pkg::COORD_W-1];
        end
        if (i_cmd.map_mul) begin
            r_p_re_hi <= HI_W'(r_a_re) * HI_W'(k_re[etf_pkg::K_W-1:etf_pkg::K_LO_W]);
            r_p_re_lo <= LO_W'(r_a_re) * LO_W'(k_re[etf_pkg::K_LO_W-1:0]);
            r_p_im_hi <= HI_W'(r_a_im) * HI_W'(k_im[etf_pkg::K_W-1:etf_pkg::K_LO_W]);
            r_p_im_lo <= LO_W'(r_a_im) * LO_W'(k_im[etf_pkg::K_LO_W-1:0]);
        end
        if (i_cmd.map_init) begin
            r_cnt <= '0;
            if (i_cfg.mode == etf_pkg::MODE_JULIA) begin
                r_zr <= map_re;
                r_zi <= map_im;
                r_cr <= etf_pkg::Z_W'(i_cfg.c_re);
                r_ci <= etf_pkg::Z_W'(i_cfg.c_im);
            end else begin
                r_zr <= '0;
                r_zi <= '0;
                r_cr <= map_re;
                r_ci <= map_im;
            end
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + etf_pkg::CNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_aa <= r_zr * r_zr;
            r_bb <= r_zi * r_zi;
            r_ab <= r_zr * r_zi;
        end
        if (i_cmd.z_update) begin
            r_zr <= f_sat_z(nr);
            r_zi <= f_sat_z(ni);
        end
        if (i_cmd.out_load) begin
            r_iter_out <= r_cnt;
            if (i_cfg.mode == etf_pkg::MODE_JULIA) begin
                r_red   <= ju_col;
                r_green <= etf_pkg::COLOR_W'(unused_c);
                r_blue  <= ju_col;
            end else begin
                r_red   <= etf_pkg::COLOR_W'(etf_pkg::RED_BASE)
                         + p_red[CPROD_W-1:etf_pkg::DIV10_SHIFT];
                r_green <= etf_pkg::COLOR_W'(etf_pkg::GREEN_BASE)
                         + p_green[CPROD_W-1:etf_pkg::DIV10_SHIFT];
                r_blue  <= etf_pkg::COLOR_W'(etf_pkg::BLUE_BASE)
                         + p_blue[CPROD_W-1:etf_pkg::DIV10_SHIFT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_load;
        end
    end

    assign o_red             = r_red;
    assign o_green           = r_green;
    assign o_blue            = r_blue;
    assign o_iteration_count = r_iter_out;
    assign o_valid           = r_valid;

endmodule

// File: sv/escape_time_fractal_pixel.sv
// Top level of the escape-time fractal pixel colorer (Mandelbrot / Julia modes).
//
//  Channel  | Handshake                         | Payload
//  ---------+-----------------------------------+-------------------------------------------
//  request  | start, busy (taken: start & !busy)| i_pixel_x, i_pixel_y
//  result   | o_valid, one cycle, no stall      | o_red, o_green, o_blue, o_iteration_count
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// A request first runs the pixel-to-plane mapping steps (MAP_ABS, MAP_MUL,
// MAP_INIT), then one multiply/step pair for each z update (a registered multiply
// for a*a, b*b, a*b, then a subtract, add and saturate step that also runs the
// escape test, in Julia mode not on the first update), one more pair for the last
// escape or limit test that ends the loop, then one coloring step. There are n
// updates (n <= max_iterations); a new request is taken only after the coloring step.
// Reset is synchronous and active low; it loads the register defaults and
// returns the sequencer to idle. The result sink cannot stall: o_valid is a
// one-cycle strobe, and busy drops in that same cycle so a new request is
// taken while the result is on the ports.
module escape_time_fractal_pixel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request
    input  logic                        start,
    output logic                        busy,
    input  logic [etf_pkg::PIX_W-1:0]   i_pixel_x,
    input  logic [etf_pkg::PIX_W-1:0]   i_pixel_y,
    // result
    output logic                        o_valid,
    output logic [etf_pkg::COLOR_W-1:0] o_red,
    output logic [etf_pkg::COLOR_W-1:0] o_green,
    output logic [etf_pkg::COLOR_W-1:0] o_blue,
    output logic [etf_pkg::CNT_W-1:0]   o_iteration_count,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [etf_pkg::ADDR_W-1:0]  paddr,
    input  logic [etf_pkg::DATA_W-1:0]  pwdata,
    output logic [etf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    etf_pkg::t_cfg     cfg;
    etf_pkg::t_dp_cmd  cmd;
    etf_pkg::t_dp_stat stat;

    // Mode, iteration limit, Julia constant; written only while idle by the user, unchecked.
    etf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer: walk mapping, then alternate multiply and step until the
    // escape test or the iteration limit ends the loop, then drive coloring.
    etf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (cfg.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Arithmetic: hold pixel, map to Q6.26, iterate z, report escape status,
    // and register the colored result with its strobe.
    etf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .o_stat            (stat),
        .o_red             (o_red),
        .o_green           (o_green),
        .o_blue            (o_blue),
        .o_iteration_count (o_iteration_count),
        .o_valid           (o_valid)
    );

endmodule
